// ===== src/dfr_pkg.sv =====
// Shared types and constants for the byte-stuffed frame deframer.
// Holds the configuration struct, register indexes, frame modes and error codes.
package dfr_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [7:0] HEAD_CODE_RESET           = 8'd126;
   localparam logic [7:0] TAIL_CODE_RESET           = 8'd127;
   localparam logic [7:0] ESCAPE_CODE_RESET         = 8'd125;
   localparam logic [7:0] ESCAPED_HEAD_CODE_RESET   = 8'd94;
   localparam logic [7:0] ESCAPED_TAIL_CODE_RESET   = 8'd95;
   localparam logic [7:0] ESCAPED_ESCAPE_CODE_RESET = 8'd93;
   localparam logic [7:0] BUFFER_LIMIT_RESET        = 8'd64;

   typedef enum logic [2:0] {
      REG_HEAD_CODE           = 3'd0,
      REG_TAIL_CODE           = 3'd1,
      REG_ESCAPE_CODE         = 3'd2,
      REG_ESCAPED_HEAD_CODE   = 3'd3,
      REG_ESCAPED_TAIL_CODE   = 3'd4,
      REG_ESCAPED_ESCAPE_CODE = 3'd5,
      REG_BUFFER_LIMIT        = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_FRAME  = 4'b0010,
      MODE_ESCAPE = 4'b0100,
      MODE_DONE   = 4'b1000
   } frame_mode_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_BAD_ESCAPE = 2'd1,
      ERR_OVERFLOW   = 2'd2
   } error_kind_type;

   typedef struct packed {
      logic [7:0] head_code;
      logic [7:0] tail_code;
      logic [7:0] escape_code;
      logic [7:0] escaped_head_code;
      logic [7:0] escaped_tail_code;
      logic [7:0] escaped_escape_code;
      logic [7:0] buffer_limit;
   } dfr_cfg_type;

endpackage

// ===== src/dfr_csr.sv =====
// Configuration register file for the deframer, written over an APB-style port.
// Depends on dfr_pkg for the register indexes, reset values and config struct.
module dfr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dfr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [dfr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [dfr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output dfr_pkg::dfr_cfg_type                 cfg
);

   dfr_pkg::dfr_cfg_type cfg_ff;
   dfr_pkg::dfr_cfg_type cfg_in;
   dfr_pkg::reg_index_type index;
   logic       write_en;
   logic [7:0] wdata;
   logic [7:0] rdata;

   assign index    = dfr_pkg::reg_index_type'(csr_paddr[dfr_pkg::CSR_ADDR_WIDTH-1:2]);
   assign write_en = csr_psel & csr_penable & csr_pwrite;
   assign wdata    = csr_pwdata[7:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            dfr_pkg::REG_HEAD_CODE:           cfg_in.head_code = wdata;
            dfr_pkg::REG_TAIL_CODE:           cfg_in.tail_code = wdata;
            dfr_pkg::REG_ESCAPE_CODE:         cfg_in.escape_code = wdata;
            dfr_pkg::REG_ESCAPED_HEAD_CODE:   cfg_in.escaped_head_code = wdata;
            dfr_pkg::REG_ESCAPED_TAIL_CODE:   cfg_in.escaped_tail_code = wdata;
            dfr_pkg::REG_ESCAPED_ESCAPE_CODE: cfg_in.escaped_escape_code = wdata;
            dfr_pkg::REG_BUFFER_LIMIT:        cfg_in.buffer_limit = wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         dfr_pkg::REG_HEAD_CODE:           rdata = cfg_ff.head_code;
         dfr_pkg::REG_TAIL_CODE:           rdata = cfg_ff.tail_code;
         dfr_pkg::REG_ESCAPE_CODE:         rdata = cfg_ff.escape_code;
         dfr_pkg::REG_ESCAPED_HEAD_CODE:   rdata = cfg_ff.escaped_head_code;
         dfr_pkg::REG_ESCAPED_TAIL_CODE:   rdata = cfg_ff.escaped_tail_code;
         dfr_pkg::REG_ESCAPED_ESCAPE_CODE: rdata = cfg_ff.escaped_escape_code;
         dfr_pkg::REG_BUFFER_LIMIT:        rdata = cfg_ff.buffer_limit;
         default:                          rdata = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_code           <= dfr_pkg::HEAD_CODE_RESET;
         cfg_ff.tail_code           <= dfr_pkg::TAIL_CODE_RESET;
         cfg_ff.escape_code         <= dfr_pkg::ESCAPE_CODE_RESET;
         cfg_ff.escaped_head_code   <= dfr_pkg::ESCAPED_HEAD_CODE_RESET;
         cfg_ff.escaped_tail_code   <= dfr_pkg::ESCAPED_TAIL_CODE_RESET;
         cfg_ff.escaped_escape_code <= dfr_pkg::ESCAPED_ESCAPE_CODE_RESET;
         cfg_ff.buffer_limit        <= dfr_pkg::BUFFER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = {{(dfr_pkg::CSR_DATA_WIDTH-8){1'b0}}, rdata};
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== src/dfr_core.sv =====
// Deframer datapath: input register, frame state, decode logic and result register.
// Depends on dfr_pkg for the frame modes, error codes and config struct.
module dfr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  dfr_pkg::dfr_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_byte_written,
   output logic [7:0]           rsp_written_byte,
   output logic [7:0]           rsp_written_pos,
   output logic                 rsp_frame_complete,
   output logic [7:0]           rsp_frame_length,
   output logic [1:0]           rsp_error_kind
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   dfr_pkg::frame_mode_type  mode_ff, mode_in;
   logic [7:0]               pos_ff, pos_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     written_ff, written_in;
   logic [7:0]               wbyte_ff, wbyte_in;
   logic [7:0]               wpos_ff, wpos_in;
   logic                     done_ff, done_in;
   logic [7:0]               flen_ff, flen_in;
   dfr_pkg::error_kind_type  err_ff, err_in;

   logic                     advance;
   logic                     req_take;
   logic                     process;
   logic                     check;
   logic [7:0]               pos_inc;

   // The result register frees up when it is empty or its transfer happens now.
   assign advance   = ~out_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign process   = in_valid_ff & advance;
   assign pos_inc   = pos_ff + 8'd1;

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      written_in = 1'b0;
      wbyte_in   = 8'd0;
      wpos_in    = 8'd0;
      done_in    = 1'b0;
      flen_in    = 8'd0;
      err_in     = dfr_pkg::ERR_NONE;
      check      = 1'b1;

      if (in_byte_ff == cfg.head_code) begin
         // A head byte restarts the frame from any mode.
         written_in = 1'b1;
         wbyte_in   = in_byte_ff;
         pos_in     = 8'd1;
         mode_in    = dfr_pkg::MODE_FRAME;
      end else begin
         case (mode_ff)
            dfr_pkg::MODE_FRAME: begin
               if (in_byte_ff == cfg.escape_code) begin
                  mode_in = dfr_pkg::MODE_ESCAPE;
               end else if (in_byte_ff == cfg.tail_code) begin
                  written_in = 1'b1;
                  wbyte_in   = in_byte_ff;
                  wpos_in    = pos_ff;
                  pos_in     = pos_inc;
                  mode_in    = dfr_pkg::MODE_DONE;
                  done_in    = 1'b1;
                  flen_in    = pos_inc;
                  check      = 1'b0;
               end else begin
                  written_in = 1'b1;
                  wbyte_in   = in_byte_ff;
                  wpos_in    = pos_ff;
                  pos_in     = pos_inc;
               end
            end
            dfr_pkg::MODE_ESCAPE: begin
               if (in_byte_ff == cfg.escaped_head_code ||
                   in_byte_ff == cfg.escaped_tail_code ||
                   in_byte_ff == cfg.escaped_escape_code) begin
                  written_in = 1'b1;
                  if (in_byte_ff == cfg.escaped_head_code) begin
                     wbyte_in = cfg.head_code;
                  end else if (in_byte_ff == cfg.escaped_tail_code) begin
                     wbyte_in = cfg.tail_code;
                  end else begin
                     wbyte_in = cfg.escape_code;
                  end
                  wpos_in = pos_ff;
                  pos_in  = pos_inc;
                  mode_in = dfr_pkg::MODE_FRAME;
               end else begin
                  pos_in  = 8'd0;
                  mode_in = dfr_pkg::MODE_IDLE;
                  err_in  = dfr_pkg::ERR_BAD_ESCAPE;
                  check   = 1'b0;
               end
            end
            default: ;
         endcase
      end

      // Overflow applies after the byte is taken, so a written byte is still reported.
      if (check && pos_in >= cfg.buffer_limit) begin
         pos_in  = 8'd0;
         mode_in = dfr_pkg::MODE_IDLE;
         err_in  = dfr_pkg::ERR_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= dfr_pkg::MODE_IDLE;
         pos_ff       <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            mode_ff <= mode_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (process) begin
         written_ff <= written_in;
         wbyte_ff   <= wbyte_in;
         wpos_ff    <= wpos_in;
         done_ff    <= done_in;
         flen_ff    <= flen_in;
         err_ff     <= err_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_byte_written   = written_ff;
   assign rsp_written_byte   = wbyte_ff;
   assign rsp_written_pos    = wpos_ff;
   assign rsp_frame_complete = done_ff;
   assign rsp_frame_length   = flen_ff;
   assign rsp_error_kind     = err_ff;

`ifndef SYNTHESIS
   a_complete_len: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && done_ff) |-> (written_ff && flen_ff == wpos_ff + 8'd1
                                     && err_ff == dfr_pkg::ERR_NONE))
      else $error("completed frame result is inconsistent");

   a_bad_escape_no_write: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && err_ff == dfr_pkg::ERR_BAD_ESCAPE) |-> !written_ff)
      else $error("bad escape result reports a written byte");

   a_abort_resets_state: assert property (@(posedge clock) disable iff (reset)
      (process && err_in != dfr_pkg::ERR_NONE) |=>
         (mode_ff == dfr_pkg::MODE_IDLE && pos_ff == 8'd0))
      else $error("abort did not return the frame state to idle");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with an empty input register");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(process) |-> ($stable(mode_ff) && $stable(pos_ff)))
      else $error("frame state changed without a processed item");
`endif

endmodule

// ===== src/byte_stuffed_frame_deframer.sv =====
// A received byte passes through the input register and then the result register on its way to rsp_.
// Throughput: one byte per cycle while rsp_stall is low, set by the single decode step between the input
// register and the result register; a stalled result holds back one more byte.
// Reset (synchronous, active high) clears both pipeline registers, puts the frame
// state in idle at position 0 and loads the marker and limit registers defaults.
// Depends on dfr_pkg, dfr_csr and dfr_core.
module byte_stuffed_frame_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_byte_written,
   output logic [7:0]                           rsp_written_byte,
   output logic [7:0]                           rsp_written_pos,
   output logic                                 rsp_frame_complete,
   output logic [7:0]                           rsp_frame_length,
   output logic [1:0]                           rsp_error_kind,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dfr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [dfr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [dfr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   dfr_pkg::dfr_cfg_type cfg;

   dfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dfr_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_written   (rsp_byte_written),
      .rsp_written_byte   (rsp_written_byte),
      .rsp_written_pos    (rsp_written_pos),
      .rsp_frame_complete (rsp_frame_complete),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_error_kind     (rsp_error_kind)
   );

endmodule

// ===== sim/byte_stuffed_frame_deframer_test.sv =====
// Self-checking testbench for the byte-stuffed frame deframer.
// Predicts each decoded result in step with the block and compares every transfer.
// Depends on dfr_pkg and byte_stuffed_frame_deframer.
`timescale 1ns / 100ps

module byte_stuffed_frame_deframer_test;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned ITEM_TARGET = 600;
   localparam int unsigned MAX_PRINTED = 40;

   typedef struct packed {
      logic                    byte_written;
      logic [7:0]              written_byte;
      logic [7:0]              written_pos;
      logic                    frame_complete;
      logic [7:0]              frame_length;
      dfr_pkg::error_kind_type error_kind;
   } deframe_result_type;

   logic clock;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_byte_written;
   logic [7:0] rsp_written_byte;
   logic [7:0] rsp_written_pos;
   logic       rsp_frame_complete;
   logic [7:0] rsp_frame_length;
   logic [1:0] rsp_error_kind;

   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [dfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [dfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [dfr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   // Model of the deframer: its registers and its frame state.
   dfr_pkg::dfr_cfg_type    model_cfg;
   dfr_pkg::frame_mode_type model_mode;
   logic [7:0]              model_pos;

   deframe_result_type expected_deframe[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;

   // Sender bursts and receiver stall pattern.
   bit          gaps_enabled = 1'b1;
   int unsigned burst_left = 0;
   int unsigned hold_off_request = 0;
   int unsigned hold_off_left = 0;
   int unsigned stall_style = 0;
   int unsigned style_left = 0;

   byte_stuffed_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_written   (rsp_byte_written),
      .rsp_written_byte   (rsp_written_byte),
      .rsp_written_pos    (rsp_written_pos),
      .rsp_frame_complete (rsp_frame_complete),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_error_kind     (rsp_error_kind),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL byte_stuffed_frame_deframer");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTED)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Decodes one line byte against the model state, exactly one result per byte.
   function automatic deframe_result_type deframe_step(input logic [7:0] line_byte);
      deframe_result_type      r;
      logic [7:0]              next_pos;
      dfr_pkg::frame_mode_type next_mode;
      logic                    limit_checked;
      logic                    escape_ok;
      logic [7:0]              mapped;
      r = '0;
      r.error_kind = dfr_pkg::ERR_NONE;
      next_pos = model_pos;
      next_mode = model_mode;
      limit_checked = 1'b1;
      escape_ok = 1'b1;
      mapped = 8'd0;
      if (line_byte == model_cfg.head_code) begin
         r.byte_written = 1'b1;
         r.written_byte = line_byte;
         r.written_pos = 8'd0;
         next_pos = 8'd1;
         next_mode = dfr_pkg::MODE_FRAME;
      end else if (model_mode == dfr_pkg::MODE_FRAME) begin
         if (line_byte == model_cfg.escape_code) begin
            next_mode = dfr_pkg::MODE_ESCAPE;
         end else begin
            r.byte_written = 1'b1;
            r.written_byte = line_byte;
            r.written_pos = model_pos;
            next_pos = model_pos + 8'd1;
            if (line_byte == model_cfg.tail_code) begin
               next_mode = dfr_pkg::MODE_DONE;
               r.frame_complete = 1'b1;
               r.frame_length = next_pos;
               limit_checked = 1'b0;
            end
         end
      end else if (model_mode == dfr_pkg::MODE_ESCAPE) begin
         if (line_byte == model_cfg.escaped_head_code) mapped = model_cfg.head_code;
         else if (line_byte == model_cfg.escaped_tail_code) mapped = model_cfg.tail_code;
         else if (line_byte == model_cfg.escaped_escape_code) mapped = model_cfg.escape_code;
         else escape_ok = 1'b0;
         if (escape_ok) begin
            r.byte_written = 1'b1;
            r.written_byte = mapped;
            r.written_pos = model_pos;
            next_pos = model_pos + 8'd1;
            next_mode = dfr_pkg::MODE_FRAME;
         end else begin
            next_pos = 8'd0;
            next_mode = dfr_pkg::MODE_IDLE;
            r.error_kind = dfr_pkg::ERR_BAD_ESCAPE;
            limit_checked = 1'b0;
         end
      end
      if (limit_checked && next_pos >= model_cfg.buffer_limit) begin
         next_pos = 8'd0;
         next_mode = dfr_pkg::MODE_IDLE;
         r.error_kind = dfr_pkg::ERR_OVERFLOW;
      end
      model_pos = next_pos;
      model_mode = next_mode;
      return r;
   endfunction

   // Offers one byte, waits for its transfer, then perhaps ends the burst with a gap.
   task automatic send_byte(input logic [7:0] line_byte);
      int unsigned gap;
      req_valid <= 1'b1;
      req_rx_byte <= line_byte;
      do @(posedge clock); while (req_stall);
      expected_deframe.push_back(deframe_step(line_byte));
      items_sent++;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Lowers valid and waits until every decoded result has been taken.
   task automatic wait_for_drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_deframe.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic read_register(input dfr_pkg::reg_index_type index,
                                output logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata[7:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes one register, mirrors it in the model and reads it back.
   task automatic write_register(input dfr_pkg::reg_index_type index,
                                 input logic [7:0] value);
      logic [7:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {{(dfr_pkg::CSR_DATA_WIDTH-8){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         dfr_pkg::REG_HEAD_CODE:           model_cfg.head_code = value;
         dfr_pkg::REG_TAIL_CODE:           model_cfg.tail_code = value;
         dfr_pkg::REG_ESCAPE_CODE:         model_cfg.escape_code = value;
         dfr_pkg::REG_ESCAPED_HEAD_CODE:   model_cfg.escaped_head_code = value;
         dfr_pkg::REG_ESCAPED_TAIL_CODE:   model_cfg.escaped_tail_code = value;
         dfr_pkg::REG_ESCAPED_ESCAPE_CODE: model_cfg.escaped_escape_code = value;
         dfr_pkg::REG_BUFFER_LIMIT:        model_cfg.buffer_limit = value;
         default: ;
      endcase
      @(posedge clock);
      read_register(index, readback);
      if (readback !== value)
         report_mismatch("register readback", 32'(readback), 32'(value));
   endtask

   task automatic write_markers(input logic [7:0] head, input logic [7:0] tail,
                                input logic [7:0] escape, input logic [7:0] esc_head,
                                input logic [7:0] esc_tail, input logic [7:0] esc_escape,
                                input logic [7:0] limit);
      write_register(dfr_pkg::REG_HEAD_CODE, head);
      write_register(dfr_pkg::REG_TAIL_CODE, tail);
      write_register(dfr_pkg::REG_ESCAPE_CODE, escape);
      write_register(dfr_pkg::REG_ESCAPED_HEAD_CODE, esc_head);
      write_register(dfr_pkg::REG_ESCAPED_TAIL_CODE, esc_tail);
      write_register(dfr_pkg::REG_ESCAPED_ESCAPE_CODE, esc_escape);
      write_register(dfr_pkg::REG_BUFFER_LIMIT, limit);
   endtask

   // Mostly marker values, so that the special paths are hit often.
   function automatic logic [7:0] random_line_byte;
      case ($urandom_range(0, 9))
         0: return model_cfg.head_code;
         1: return model_cfg.tail_code;
         2: return model_cfg.escape_code;
         3: return model_cfg.escaped_head_code;
         4: return model_cfg.escaped_tail_code;
         5: return model_cfg.escaped_escape_code;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Sends head, a stuffed payload of random bytes and, if asked, the tail.
   task automatic send_stuffed_frame(input int unsigned payload_len, input bit with_tail);
      logic [7:0] data;
      send_byte(model_cfg.head_code);
      for (int unsigned i = 0; i < payload_len; i++) begin
         data = ($urandom_range(0, 3) == 0) ? random_line_byte() : 8'($urandom_range(0, 255));
         if (data == model_cfg.head_code) begin
            send_byte(model_cfg.escape_code);
            send_byte(model_cfg.escaped_head_code);
         end else if (data == model_cfg.tail_code) begin
            send_byte(model_cfg.escape_code);
            send_byte(model_cfg.escaped_tail_code);
         end else if (data == model_cfg.escape_code) begin
            send_byte(model_cfg.escape_code);
            send_byte(model_cfg.escaped_escape_code);
         end else begin
            send_byte(data);
         end
      end
      if (with_tail) send_byte(model_cfg.tail_code);
   endtask

   task automatic test_register_defaults;
      logic [7:0] value;
      read_register(dfr_pkg::REG_HEAD_CODE, value);
      if (value !== dfr_pkg::HEAD_CODE_RESET)
         report_mismatch("head_code reset", 32'(value), 32'(dfr_pkg::HEAD_CODE_RESET));
      read_register(dfr_pkg::REG_TAIL_CODE, value);
      if (value !== dfr_pkg::TAIL_CODE_RESET)
         report_mismatch("tail_code reset", 32'(value), 32'(dfr_pkg::TAIL_CODE_RESET));
      read_register(dfr_pkg::REG_ESCAPE_CODE, value);
      if (value !== dfr_pkg::ESCAPE_CODE_RESET)
         report_mismatch("escape_code reset", 32'(value), 32'(dfr_pkg::ESCAPE_CODE_RESET));
      read_register(dfr_pkg::REG_ESCAPED_HEAD_CODE, value);
      if (value !== dfr_pkg::ESCAPED_HEAD_CODE_RESET)
         report_mismatch("escaped_head_code reset", 32'(value),
                         32'(dfr_pkg::ESCAPED_HEAD_CODE_RESET));
      read_register(dfr_pkg::REG_ESCAPED_TAIL_CODE, value);
      if (value !== dfr_pkg::ESCAPED_TAIL_CODE_RESET)
         report_mismatch("escaped_tail_code reset", 32'(value),
                         32'(dfr_pkg::ESCAPED_TAIL_CODE_RESET));
      read_register(dfr_pkg::REG_ESCAPED_ESCAPE_CODE, value);
      if (value !== dfr_pkg::ESCAPED_ESCAPE_CODE_RESET)
         report_mismatch("escaped_escape_code reset", 32'(value),
                         32'(dfr_pkg::ESCAPED_ESCAPE_CODE_RESET));
      read_register(dfr_pkg::REG_BUFFER_LIMIT, value);
      if (value !== dfr_pkg::BUFFER_LIMIT_RESET)
         report_mismatch("buffer_limit reset", 32'(value), 32'(dfr_pkg::BUFFER_LIMIT_RESET));
   endtask

   // Reset markers: ignored bytes, all three escape pairs, head after escape,
   // bad escape, tail completion and bytes after a completed frame.
   task automatic test_default_markers;
      logic [7:0] seq[] = '{8'h00, 8'hFF, 8'h7F, 8'h7D, 8'h7E, 8'h00, 8'hFF,
                            8'h7D, 8'h5E, 8'h7D, 8'h5F, 8'h7D, 8'h5D, 8'h7D, 8'h7E,
                            8'h41, 8'h7F, 8'h55, 8'h7D, 8'h7E, 8'h7D, 8'h00, 8'h33,
                            8'h7E, 8'h7F};
      foreach (seq[i]) send_byte(seq[i]);
      wait_for_drain();
   endtask

   // Limit edges: tail skips the check, overflow on byte and mapped escape,
   // limits of one and zero, and a limit lowered in the middle of a frame.
   task automatic test_limit_edges;
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd3);
      send_byte(8'h7E); send_byte(8'h01); send_byte(8'h7F);
      send_byte(8'h7E); send_byte(8'h01); send_byte(8'h02);
      send_byte(8'h7E); send_byte(8'h7D); send_byte(8'h7D);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd2);
      send_byte(8'h7E); send_byte(8'h7D); send_byte(8'h5D);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd1);
      send_byte(8'h7E); send_byte(8'h10);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd0);
      send_byte(8'h00); send_byte(8'h7F); send_byte(8'h7E);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd64);
      send_byte(8'h7E); send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd2);
      send_byte(8'h04);
      send_byte(8'h7E); send_byte(8'h7D);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd1);
      send_byte(8'h5E);
      send_byte(8'h7E);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd64);
      send_byte(8'h7E); send_byte(8'h01); send_byte(8'h02);
      wait_for_drain();
      write_register(dfr_pkg::REG_BUFFER_LIMIT, 8'd2);
      send_byte(8'h7F);
      wait_for_drain();
   endtask

   // Markers at the byte extremes and the largest limit, filled by one frame of
   // full length so that the last position and the longest length are reached.
   task automatic test_extreme_markers;
      write_markers(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h02, 8'h80, 8'd255);
      gaps_enabled = 1'b0;
      send_stuffed_frame(253, 1'b1);
      gaps_enabled = 1'b1;
      send_stuffed_frame(3, 1'b1);
      wait_for_drain();
      write_markers(8'hFF, 8'h00, 8'hFE, 8'h01, 8'h7F, 8'h00, 8'd2);
      send_stuffed_frame(0, 1'b1);
      send_stuffed_frame(2, 1'b1);
      send_byte(8'hFE); send_byte(8'h00);
      wait_for_drain();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // bytes, so the block fills up and stalls its input.
   task automatic test_backpressure;
      write_markers(8'h7E, 8'h7F, 8'h7D, 8'h5E, 8'h5F, 8'h5D, 8'd16);
      gaps_enabled = 1'b0;
      hold_off_request = 80;
      for (int i = 0; i < 4; i++) send_stuffed_frame($urandom_range(2, 8), 1'b1);
      gaps_enabled = 1'b1;
      wait_for_drain();
   endtask

   // Random phases: new markers and limit each time, then mostly well-formed
   // stuffed frames, with noise, unterminated frames and broken escapes.
   task automatic test_random_traffic;
      logic [7:0]  limit;
      int unsigned phase_end;
      int unsigned max_len;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0: limit = 8'($urandom_range(0, 1));
            1: limit = 8'd2;
            2: limit = 8'd255;
            3: limit = 8'd64;
            default: limit = 8'($urandom_range(3, 20));
         endcase
         write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), limit);
         gaps_enabled = ($urandom_range(0, 3) != 0);
         max_len = (limit > 24) ? 24 : limit + 2;
         phase_end = items_sent + 70;
         while (items_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0: send_byte(random_line_byte());
               1: send_stuffed_frame($urandom_range(0, max_len), 1'b0);
               2: begin
                  send_stuffed_frame($urandom_range(0, 4), 1'b0);
                  send_byte(model_cfg.escape_code);
                  send_byte(random_line_byte());
               end
               default: send_stuffed_frame($urandom_range(0, max_len), 1'b1);
            endcase
         end
         wait_for_drain();
      end
   endtask

   // Receiver stall pattern: the style is redrawn at random when its countdown runs out, and a
   // requested hold-off overrides it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_off_request != 0) begin
            hold_off_left = hold_off_request;
            hold_off_request = 0;
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(16, 96);
         end else begin
            style_left--;
         end
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Each result transfer is matched against the oldest decoded expectation.
   always @(posedge clock) begin
      deframe_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_deframe.size() == 0) begin
            report_mismatch("unexpected result, written_pos", 32'(rsp_written_pos), 32'd0);
         end else begin
            want = expected_deframe.pop_front();
            if (rsp_byte_written !== want.byte_written)
               report_mismatch("byte_written", 32'(rsp_byte_written),
                               32'(want.byte_written));
            if (rsp_written_byte !== want.written_byte)
               report_mismatch("written_byte", 32'(rsp_written_byte),
                               32'(want.written_byte));
            if (rsp_written_pos !== want.written_pos)
               report_mismatch("written_pos", 32'(rsp_written_pos), 32'(want.written_pos));
            if (rsp_frame_complete !== want.frame_complete)
               report_mismatch("frame_complete", 32'(rsp_frame_complete),
                               32'(want.frame_complete));
            if (rsp_frame_length !== want.frame_length)
               report_mismatch("frame_length", 32'(rsp_frame_length),
                               32'(want.frame_length));
            if (rsp_error_kind !== want.error_kind)
               report_mismatch("error_kind", 32'(rsp_error_kind), 32'(want.error_kind));
         end
      end
   end

   initial begin
      model_cfg.head_code = dfr_pkg::HEAD_CODE_RESET;
      model_cfg.tail_code = dfr_pkg::TAIL_CODE_RESET;
      model_cfg.escape_code = dfr_pkg::ESCAPE_CODE_RESET;
      model_cfg.escaped_head_code = dfr_pkg::ESCAPED_HEAD_CODE_RESET;
      model_cfg.escaped_tail_code = dfr_pkg::ESCAPED_TAIL_CODE_RESET;
      model_cfg.escaped_escape_code = dfr_pkg::ESCAPED_ESCAPE_CODE_RESET;
      model_cfg.buffer_limit = dfr_pkg::BUFFER_LIMIT_RESET;
      model_mode = dfr_pkg::MODE_IDLE;
      model_pos = 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_default_markers();
      test_limit_edges();
      test_extreme_markers();
      test_backpressure();
      test_random_traffic();

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASS byte_stuffed_frame_deframer");
      else
         $display("FAIL byte_stuffed_frame_deframer");
      $finish;
   end

endmodule
